### rtl/echo_width_average_hysteresis_assert.svh
// Assertion macros shared by the echo width averager RTL
`ifndef ECHO_WIDTH_AVERAGE_HYSTERESIS_ASSERT_SVH
`define ECHO_WIDTH_AVERAGE_HYSTERESIS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define EWAH_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define EWAH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ewah_pkg.sv
// Shared types and constants of the echo width averager
`default_nettype none

package ewah_pkg;

    // Default sizing
    localparam int EWAH_WINDOW_LENGTH = 25;
    localparam int EWAH_COUNT_BITS    = 16;
    localparam int EWAH_QUEUE_DEPTH   = 4;

    // Field and bus widths
    localparam int LIMIT_W     = 16;
    localparam int OUT_FIELD_W = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 40;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_NEAR_LIMIT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAR_LIMIT  = 1'b1;

    // Register reset values
    localparam logic [LIMIT_W-1:0] NEAR_LIMIT_RESET = 16'd1800;
    localparam logic [LIMIT_W-1:0] FAR_LIMIT_RESET  = 16'd2000;

    // Lamp codes
    typedef enum logic [1:0] {
        LAMP_NONE = 2'd0,
        LAMP_NEAR = 2'd1,
        LAMP_FAR  = 2'd2
    } lamp_t;

    // Width queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

### rtl/ewah_front.sv
// Front end: takes one echo sample per transfer and measures high pulses
`default_nettype none

module ewah_front #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   sample_valid,
    output logic                        sample_ready,
    input  wire logic                   level,
    input  wire ewah_pkg::q_status_t    q_status,
    output logic                        push,
    output logic [COUNT_BITS-1:0]       push_width
);
    import ewah_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                  in_pulse_reg, in_pulse_next;
    logic [COUNT_BITS-1:0] high_cnt_reg, high_cnt_next;
    logic                  accept;

    // Stall only when the queue cannot take a finished width
    assign sample_ready = !q_status.full;
    assign accept       = sample_valid && sample_ready;

    // Pulse tracking: wait for high, count highs, hand over on the fall
    always_comb
    begin
        in_pulse_next = in_pulse_reg;
        high_cnt_next = high_cnt_reg;
        push          = 1'b0;
        if (accept)
        begin
            if (!in_pulse_reg)
            begin
                if (level)
                begin
                    in_pulse_next = 1'b1;
                    high_cnt_next = COUNT_BITS'(1);
                end
            end
            else if (level)
            begin
                if (high_cnt_reg != COUNT_MAX)
                    high_cnt_next = high_cnt_reg + COUNT_BITS'(1);
            end
            else
            begin
                push          = 1'b1;
                in_pulse_next = 1'b0;
                high_cnt_next = '0;
            end
        end
    end

    assign push_width = high_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_pulse_reg <= 1'b0;
            high_cnt_reg <= '0;
        end
        else
        begin
            in_pulse_reg <= in_pulse_next;
            high_cnt_reg <= high_cnt_next;
        end
    end

endmodule

`default_nettype wire

### rtl/ewah_queue.sv
// Short FIFO of finished pulse widths between front and back end
`default_nettype none
`include "echo_width_average_hysteresis_assert.svh"

module ewah_queue #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic [DATA_W-1:0]  push_data,
    input  wire logic               pop,
    output logic [DATA_W-1:0]       head_data,
    output ewah_pkg::q_status_t     status
);
    import ewah_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_data    = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    `EWAH_ASSERT_IMPLIES(a_no_push_full, push, !status.full, "width pushed into full queue")
    `EWAH_ASSERT_IMPLIES(a_no_pop_empty, pop, !status.empty, "width popped from empty queue")
    `EWAH_ASSERT_IMPLIES(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue overfilled")

endmodule

`default_nettype wire

### rtl/ewah_back.sv
// Back end: width window, running sum, average by reciprocal, lamp and result
`default_nettype none
`include "echo_width_average_hysteresis_assert.svh"

module ewah_back #(
    parameter int WINDOW_LENGTH = 25,
    parameter int COUNT_BITS    = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ewah_pkg::q_status_t            q_status,
    input  wire logic [COUNT_BITS-1:0]          head_width,
    output logic                                pop,
    input  wire logic [ewah_pkg::LIMIT_W-1:0]   near_limit,
    input  wire logic [ewah_pkg::LIMIT_W-1:0]   far_limit,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output logic [ewah_pkg::OUT_FIELD_W-1:0]    pulse_width,
    output logic [ewah_pkg::OUT_FIELD_W-1:0]    window_average,
    output logic [1:0]                          lamp_state,
    output logic                                window_warm
);
    import ewah_pkg::*;

    localparam int SLOT_W    = $clog2(WINDOW_LENGTH);
    localparam int SUM_W     = COUNT_BITS + $clog2(WINDOW_LENGTH);
    localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW_LENGTH);
    localparam int RECIP_W   = SUM_W + 1;
    localparam logic [63:0] RECIP =
        ((64'd1 << DIV_SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
    localparam int LO_W      = SUM_W / 2;
    localparam int HI_W      = SUM_W - LO_W;
    localparam int PLO_W     = LO_W + RECIP_W;
    localparam int PHI_W     = HI_W + RECIP_W;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int CMP_W     = (COUNT_BITS > OUT_FIELD_W) ? COUNT_BITS : OUT_FIELD_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LENGTH - 1);

    logic adv;

    // Stage A: window read and write
    logic [COUNT_BITS-1:0]    win_mem [WINDOW_LENGTH];
    logic [WINDOW_LENGTH-1:0] win_valid_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic                     a_valid_reg, a_oldv_reg;
    logic [COUNT_BITS-1:0]    a_old_reg, a_width_reg;

    // Stage B: running sum and fill count
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [SLOT_W-1:0]        gath_reg, gath_next;
    logic                     b_valid_reg, b_warm_reg;
    logic [COUNT_BITS-1:0]    b_width_reg, old_val;

    // Stage C: partial products
    logic                     c_valid_reg, c_warm_reg;
    logic [COUNT_BITS-1:0]    c_width_reg;
    logic [PLO_W-1:0]         c_plo_reg;
    logic [PHI_W-1:0]         c_phi_reg;

    // Stage D: average
    logic [PROD_W-1:0]        prod;
    logic                     d_valid_reg, d_warm_reg;
    logic [COUNT_BITS-1:0]    d_width_reg, d_avg_reg;

    // Result register and lamp
    lamp_t                    lamp_reg, lamp_next;
    logic                     load_out;
    logic [CMP_W-1:0]         avg_ext, width_ext;
    logic                     out_valid_reg, out_warm_reg;
    lamp_t                    out_lamp_reg;
    logic [OUT_FIELD_W-1:0]   out_width_reg, out_avg_reg;

    // Whole pipeline moves when the result register is free or being taken
    assign adv      = !out_valid_reg || res_ready;
    assign pop      = adv && !q_status.empty;
    assign load_out = adv && d_valid_reg;

    // Window memory: read oldest entry, overwrite it with the new width
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_old_reg         <= win_mem[slot_reg];
            win_mem[slot_reg] <= head_width;
            a_width_reg       <= head_width;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            win_valid_reg <= '0;
            a_valid_reg   <= 1'b0;
            a_oldv_reg    <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= pop;
            if (pop)
            begin
                a_oldv_reg              <= win_valid_reg[slot_reg];
                win_valid_reg[slot_reg] <= 1'b1;
                slot_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
            end
        end
    end

    // Running sum update; a never-written entry counts as zero
    always_comb
    begin
        old_val   = a_oldv_reg ? a_old_reg : '0;
        sum_next  = sum_reg - SUM_W'(old_val) + SUM_W'(a_width_reg);
        gath_next = (gath_reg == LAST_SLOT) ? gath_reg : gath_reg + SLOT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            gath_reg    <= '0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid_reg;
            if (a_valid_reg)
            begin
                sum_reg  <= sum_next;
                gath_reg <= gath_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && a_valid_reg)
        begin
            b_width_reg <= a_width_reg;
            b_warm_reg  <= (gath_next == LAST_SLOT);
        end
    end

    // Divide by window length: sum times reciprocal, split in two halves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (adv)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && b_valid_reg)
        begin
            c_plo_reg   <= PLO_W'(sum_reg[LO_W-1:0]) * PLO_W'(RECIP_W'(RECIP));
            c_phi_reg   <= PHI_W'(sum_reg[SUM_W-1:LO_W]) * PHI_W'(RECIP_W'(RECIP));
            c_width_reg <= b_width_reg;
            c_warm_reg  <= b_warm_reg;
        end
    end

    // Combine partial products and keep the quotient bits
    assign prod = PROD_W'(c_plo_reg) + (PROD_W'(c_phi_reg) << LO_W);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (adv)
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && c_valid_reg)
        begin
            d_avg_reg   <= prod[DIV_SHIFT +: COUNT_BITS];
            d_width_reg <= c_width_reg;
            d_warm_reg  <= c_warm_reg;
        end
    end

    // Hysteresis lamp; near test wins when the limits cross
    always_comb
    begin
        avg_ext   = CMP_W'(d_avg_reg);
        width_ext = CMP_W'(d_width_reg);
        lamp_next = lamp_reg;
        if (d_warm_reg)
        begin
            priority if (avg_ext < CMP_W'(near_limit))
                lamp_next = LAMP_NEAR;
            else if (avg_ext > CMP_W'(far_limit))
                lamp_next = LAMP_FAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lamp_reg      <= LAMP_NONE;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= d_valid_reg;
            if (d_valid_reg)
                lamp_reg <= lamp_next;
        end
    end

    // Result fields, clamped to 16 bits for wide counters
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_width_reg <= (width_ext > CMP_W'(16'hFFFF)) ? 16'hFFFF
                                                           : width_ext[OUT_FIELD_W-1:0];
            out_avg_reg   <= (avg_ext > CMP_W'(16'hFFFF)) ? 16'hFFFF
                                                         : avg_ext[OUT_FIELD_W-1:0];
            out_lamp_reg  <= lamp_next;
            out_warm_reg  <= d_warm_reg;
        end
    end

    assign res_valid      = out_valid_reg;
    assign pulse_width    = out_width_reg;
    assign window_average = out_avg_reg;
    assign lamp_state     = out_lamp_reg;
    assign window_warm    = out_warm_reg;

    `EWAH_ASSERT_IMPLIES(a_gath_bound, 1'b1, gath_reg <= LAST_SLOT, "fill count past window")
    `EWAH_ASSERT_NEXT(a_lamp_sticky, lamp_reg != LAMP_NONE, lamp_reg != LAMP_NONE, "lamp cleared")
    `EWAH_ASSERT_NEXT(a_lamp_hold, !(load_out && d_warm_reg), $stable(lamp_reg), "lamp moved cold")

endmodule

`default_nettype wire

### rtl/echo_width_average_hysteresis.sv
// Top level of the echo pulse width averager with hysteresis lamp
//
//  Channel   Direction  Handshake            Contents
//  s_*       in         s_tvalid / s_tready  one echo pin sample per transfer
//  m_*       out        m_tvalid / m_tready  one result per finished high pulse
//  cfg_*     in         cfg_wen              near_limit (0), far_limit (1)
//
//  Accepts one sample every cycle unless the queue is full; stages A-D and
//  the result register retire one width per cycle unless m_* stalls.
//  s_tready drops only when the 4-entry width queue is full, i.e. when m_*
//  has been stalled long enough to back up the window/divide pipeline.
//  Reset is immediate: window entries carry valid bits, so no clearing pass.
`default_nettype none

module echo_width_average_hysteresis #(
    parameter int WINDOW_LENGTH = ewah_pkg::EWAH_WINDOW_LENGTH,
    parameter int COUNT_BITS    = ewah_pkg::EWAH_COUNT_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // [0] echo_level, [7:1] zero
    input  wire logic [ewah_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [15:0] pulse_width, [31:16] window_average, [33:32] lamp_state,
    // [34] window_warm, [39:35] zero
    output logic [ewah_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               cfg_wen,
    input  wire logic [ewah_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [ewah_pkg::LIMIT_W-1:0]       cfg_data
);
    import ewah_pkg::*;

    logic [LIMIT_W-1:0]     near_limit_reg, far_limit_reg;
    q_status_t              q_status;
    logic                   push, pop;
    logic [COUNT_BITS-1:0]  push_width, head_width;
    logic [OUT_FIELD_W-1:0] pulse_width, window_average;
    logic [1:0]             lamp_state;
    logic                   window_warm;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_limit_reg <= NEAR_LIMIT_RESET;
            far_limit_reg  <= FAR_LIMIT_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_NEAR_LIMIT: near_limit_reg <= cfg_data;
                CFG_FAR_LIMIT:  far_limit_reg  <= cfg_data;
                default:        near_limit_reg <= near_limit_reg;
            endcase
        end
    end

    ewah_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (s_tvalid),
        .sample_ready (s_tready),
        .level        (s_tdata[0]),
        .q_status     (q_status),
        .push         (push),
        .push_width   (push_width)
    );

    ewah_queue #(
        .DATA_W (COUNT_BITS),
        .DEPTH  (EWAH_QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_width),
        .pop       (pop),
        .head_data (head_width),
        .status    (q_status)
    );

    ewah_back #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .COUNT_BITS    (COUNT_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .head_width     (head_width),
        .pop            (pop),
        .near_limit     (near_limit_reg),
        .far_limit      (far_limit_reg),
        .res_valid      (m_tvalid),
        .res_ready      (m_tready),
        .pulse_width    (pulse_width),
        .window_average (window_average),
        .lamp_state     (lamp_state),
        .window_warm    (window_warm)
    );

    // Result packing
    assign m_tdata = {5'b0, window_warm, lamp_state, window_average, pulse_width};

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the echo pulse width averager with hysteresis lamp
`timescale 1ns / 1ps

module testbench;
    import ewah_pkg::*;

    localparam int WINDOW        = EWAH_WINDOW_LENGTH;
    localparam int WARM_COUNT    = EWAH_WINDOW_LENGTH - 1;
    localparam logic [EWAH_COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int SUM_W         = EWAH_COUNT_BITS + 5;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 10;

    // One result as it leaves the block
    typedef struct packed {
        logic [OUT_FIELD_W-1:0] pulse_width;
        logic [OUT_FIELD_W-1:0] window_average;
        lamp_t                  lamp_state;
        logic                   window_warm;
    } echo_result_t;

    logic                   clk;
    logic                   rst_n;
    // [0] echo_level, [7:1] zero
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    // [15:0] pulse_width, [31:16] window_average, [33:32] lamp_state, [34] window_warm
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   cfg_wen;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [LIMIT_W-1:0]     cfg_data;

    // Predictor state
    logic [EWAH_COUNT_BITS-1:0] width_ring [WINDOW];
    int                         ring_slot;
    logic [SUM_W-1:0]           ring_total;
    int                         widths_seen;
    logic [EWAH_COUNT_BITS-1:0] high_run;
    bit                         pulse_open;
    lamp_t                      lamp_now;
    logic [LIMIT_W-1:0]         near_limit_now;
    logic [LIMIT_W-1:0]         far_limit_now;

    echo_result_t echo_expected [$];

    int error_count;
    int sample_count;
    int result_count;
    int quiet_cycles;

    // Sender and receiver behaviour
    bit sender_gaps;
    int burst_left;
    bit rx_stalls;
    bit hold_request;
    int hold_len;

    echo_width_average_hysteresis dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Predictor back to its reset state
    task automatic clear_echo_predictor();
        for (int i = 0; i < WINDOW; i++)
        begin
            width_ring[i] = '0;
        end
        ring_slot      = 0;
        ring_total     = '0;
        widths_seen    = 0;
        high_run       = '0;
        pulse_open     = 1'b0;
        lamp_now       = LAMP_NONE;
        near_limit_now = NEAR_LIMIT_RESET;
        far_limit_now  = FAR_LIMIT_RESET;
    endtask

    // Advance the predictor by one sample; a falling edge queues one result
    task automatic predict_echo_sample(input logic level);
        echo_result_t               res;
        logic [EWAH_COUNT_BITS-1:0] finished_width;
        logic [SUM_W-1:0]           mean;
        if (!pulse_open)
        begin
            if (level)
            begin
                pulse_open = 1'b1;
                high_run   = EWAH_COUNT_BITS'(1);
            end
        end
        else if (level)
        begin
            // saturate rather than wrap
            if (high_run != COUNT_MAX)
                high_run++;
        end
        else
        begin
            finished_width = high_run;
            pulse_open     = 1'b0;
            high_run       = '0;
            ring_total     = ring_total - width_ring[ring_slot] + finished_width;
            width_ring[ring_slot] = finished_width;
            ring_slot      = (ring_slot + 1) % WINDOW;
            if (widths_seen < WARM_COUNT)
                widths_seen++;
            mean = SUM_W'(ring_total / WINDOW);
            // near test takes priority when the limits cross
            if (widths_seen >= WARM_COUNT)
            begin
                if (mean < near_limit_now)
                    lamp_now = LAMP_NEAR;
                else if (mean > far_limit_now)
                    lamp_now = LAMP_FAR;
            end
            res.pulse_width    = finished_width;
            res.window_average = mean[OUT_FIELD_W-1:0];
            res.lamp_state     = lamp_now;
            res.window_warm    = (widths_seen >= WARM_COUNT);
            echo_expected.push_back(res);
            result_count++;
        end
    endtask

    // Offer one sample, in bursts with random gaps when sender_gaps is set, and wait for the transfer
    task automatic send_sample(input logic level);
        if (burst_left == 0)
        begin
            if (sender_gaps)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-1){1'b0}}, level};
        do
            @(posedge clk);
        while (!s_tready);
        predict_echo_sample(level);
        sample_count++;
    endtask

    task automatic send_pulse(input int high_len, input int low_len);
        for (int i = 0; i < high_len; i++)
        begin
            send_sample(1'b1);
        end
        for (int i = 0; i < low_len; i++)
        begin
            send_sample(1'b0);
        end
    endtask

    // Stop offering and let every expected result drain, then settle
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (echo_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both limits while the block is idle
    task automatic set_limits(input logic [LIMIT_W-1:0] near_l, input logic [LIMIT_W-1:0] far_l);
        wait_for_results();
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_NEAR_LIMIT;
        cfg_data  <= near_l;
        @(posedge clk);
        cfg_index <= CFG_FAR_LIMIT;
        cfg_data  <= far_l;
        @(posedge clk);
        cfg_wen <= 1'b0;
        near_limit_now = near_l;
        far_limit_now  = far_l;
    endtask

    // Lows while waiting, then short pulses back to back
    task automatic test_short_pulses();
        sender_gaps = 1'b0;
        rx_stalls   = 1'b0;
        repeat (3) send_sample(1'b0);
        send_pulse(1, 1);
        send_pulse(2, 1);
        send_pulse(1, 1);
        send_pulse(3, 2);
        wait_for_results();
    endtask

    // Reset limits: warm-up with short pulses, which sets the near lamp
    task automatic test_default_lamp();
        sender_gaps = 1'b1;
        rx_stalls   = 1'b1;
        repeat (24) send_pulse($urandom_range(2, 6), 1);
        repeat (6) send_pulse($urandom_range(1, 4), 1);
        wait_for_results();
    endtask

    // Limits at their extremes, crossed ones included
    task automatic test_limit_extremes();
        sender_gaps = 1'b1;
        rx_stalls   = 1'b1;
        set_limits(16'h0000, 16'hFFFF);
        repeat (4) send_pulse($urandom_range(1, 8), 1);
        set_limits(16'hFFFF, 16'h0000);
        repeat (4) send_pulse($urandom_range(1, 8), 1);
        set_limits(16'h0000, 16'h0000);
        repeat (4) send_pulse($urandom_range(1, 8), 1);
        set_limits(16'hFFFF, 16'hFFFF);
        repeat (4) send_pulse($urandom_range(1, 8), 1);
        wait_for_results();
    endtask

    // Long receiver hold while short pulses keep coming, so the input stalls
    task automatic test_backpressure();
        set_limits(16'd3, 16'd9);
        sender_gaps  = 1'b0;
        rx_stalls    = 1'b0;
        hold_len     = 150;
        hold_request = 1'b1;
        repeat (60) send_pulse(1, 1);
        wait_for_results();
    endtask

    // Random phases: mostly well-formed pulses, some noise samples
    task automatic test_random_traffic();
        int                 first_sample;
        int                 first_result;
        int                 phase_end;
        logic [LIMIT_W-1:0] near_l;
        logic [LIMIT_W-1:0] far_l;
        first_sample = sample_count;
        first_result = result_count;
        while ((sample_count - first_sample) < 220 || (result_count - first_result) < 15)
        begin
            near_l = LIMIT_W'($urandom_range(0, 25));
            if ($urandom_range(0, 3) == 0)
                far_l = near_l / 2;
            else
                far_l = LIMIT_W'(near_l + $urandom_range(0, 15));
            set_limits(near_l, far_l);
            sender_gaps = ($urandom_range(0, 3) != 0);
            rx_stalls   = ($urandom_range(0, 3) != 0);
            phase_end   = sample_count + $urandom_range(60, 140);
            while (sample_count < phase_end)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_sample(1'($urandom_range(0, 1)));
                else if ($urandom_range(0, 19) == 0)
                    send_pulse($urandom_range(41, 80), $urandom_range(1, 4));
                else
                    send_pulse($urandom_range(1, 12), $urandom_range(1, 4));
            end
        end
        wait_for_results();
    endtask

    // Receiver: a rotating stall pattern, all-ready stretches, and the long hold
    initial
    begin
        logic [15:0] stall_pattern;
        int          pattern_age;
        pattern_age = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge clk);
            end
            else if (!rx_stalls)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                if (pattern_age == 0)
                begin
                    stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
                    pattern_age   = 64;
                end
                m_tready <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
                pattern_age--;
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        echo_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (echo_expected.size() == 0)
            begin
                $error("unexpected result transfer: m_tdata %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = echo_expected.pop_front();
                if (m_tdata[15:0] !== want.pulse_width)
                begin
                    $error("pulse_width: expected %0d, actual %0d",
                           want.pulse_width, m_tdata[15:0]);
                    error_count++;
                end
                if (m_tdata[31:16] !== want.window_average)
                begin
                    $error("window_average: expected %0d, actual %0d",
                           want.window_average, m_tdata[31:16]);
                    error_count++;
                end
                if (m_tdata[33:32] !== want.lamp_state)
                begin
                    $error("lamp_state: expected %0d, actual %0d",
                           want.lamp_state, m_tdata[33:32]);
                    error_count++;
                end
                if (m_tdata[34] !== want.window_warm)
                begin
                    $error("window_warm: expected %0d, actual %0d",
                           want.window_warm, m_tdata[34]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long without any transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Test sequence
    initial
    begin
        error_count  = 0;
        sample_count = 0;
        result_count = 0;
        quiet_cycles = 0;
        burst_left   = 0;
        sender_gaps  = 1'b0;
        rx_stalls    = 1'b0;
        hold_request = 1'b0;
        hold_len     = 0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wen   <= 1'b0;
        cfg_index <= CFG_NEAR_LIMIT;
        cfg_data  <= '0;
        clear_echo_predictor();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_pulses();
        test_default_lamp();
        test_limit_extremes();
        test_backpressure();
        test_random_traffic();

        wait_for_results();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
